/* hdl/cws_pkg.sv */
package cws_pkg;

	localparam int WINDOW_MAX_DEF = 256;
	localparam int SEQ_BITS_DEF   = 32;

	localparam int CMD_W    = 2;
	localparam int ACK_W    = 32;
	localparam int PEER_W   = 16;
	localparam int STATUS_W = 3;
	localparam int SEQ_W    = 32;
	localparam int COUNT_W  = 9;
	localparam int WIN_W    = 16;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 80;
	localparam int S_TUSER_W = CMD_W;
	localparam int M_TUSER_W = STATUS_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int SLOTS_W    = 9;

	localparam logic [SLOTS_W-1:0] RESET_SLOTS   = 9'd16;
	localparam logic [WIN_W-1:0]   RESET_ADV     = 16'd16;
	localparam logic [WIN_W-1:0]   MIN_THRESHOLD = 16'd2;
	localparam logic [WIN_W-1:0]   WIN_SAT       = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOTS   = 1'b0,
		REG_INIT_ADV = 1'b1
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_GRANT   = 2'd1,
		CMD_ACK     = 2'd2,
		CMD_TIMEOUT = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQUEUED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_OLD_ACK   = 3'd2,
		ST_DUP_ACK   = 3'd3,
		ST_ACK_DONE  = 3'd4,
		ST_FAST_RETX = 3'd5,
		ST_TIMEOUT   = 3'd6,
		ST_GRANT     = 3'd7
	} status_t;

endpackage

/* hdl/congestion_window_sender.sv */
// Sender window bookkeeping with Reno-style congestion control. Each input item is one
// event (enqueue, send grant, ack, retransmit timeout, selected by s_tuser) and gives
// exactly one result item whose kind is on m_tuser. An item is registered on entry into
// the input stage and evaluated there against the window state; its result is loaded
// into the output register once that register is free or being taken, and is offered
// on m_tvalid from there. One item is taken every cycle while the output side keeps up;
// a stalled result holds the input stage and so the input. Configuration writes must
// only be issued while no item is in the block; writing the initial advertised window
// also reloads the advertised window and the slow start threshold.
module congestion_window_sender #(
	parameter int WINDOW_MAX = cws_pkg::WINDOW_MAX_DEF,
	parameter int SEQ_BITS   = cws_pkg::SEQ_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cws_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// ack_seq[31:0], peer_window[47:32]
	input  logic [cws_pkg::S_TDATA_W-1:0]    s_tdata,
	// command[1:0]
	input  logic [cws_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// seq[31:0], count[40:32], cwin_now[56:41], threshold_now[72:57], queue_empty[73]
	output logic [cws_pkg::M_TDATA_W-1:0]    m_tdata,
	// status[2:0]
	output logic [cws_pkg::M_TUSER_W-1:0]    m_tuser
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int GW    = ((cws_pkg::WIN_W > CNT_W) ? cws_pkg::WIN_W : CNT_W) + 2;
	localparam int WW    = cws_pkg::WIN_W;

	// input stage
	logic                          valid_s1;
	cws_pkg::cmd_t                 cmd_s1;
	logic [cws_pkg::ACK_W-1:0]     ack_s1;
	logic [cws_pkg::PEER_W-1:0]    peer_s1;

	// configuration and window state
	logic [cws_pkg::SLOTS_W-1:0]   slots_q;
	logic [WW-1:0]                 cwin_q, ssth_q, credit_q, adv_q;
	logic [CNT_W-1:0]              inf_q, queued_q, sa_q;
	logic [SEQ_BITS-1:0]           base_q, next_q, last_q;
	logic [1:0]                    dup_q;

	logic [WW-1:0]                 cwin_n, ssth_n, credit_n, adv_n;
	logic [CNT_W-1:0]              inf_n, queued_n, sa_n;
	logic [SEQ_BITS-1:0]           base_n, next_n, last_n;
	logic [1:0]                    dup_n;

	// result register
	logic                          out_valid_q;
	cws_pkg::status_t              status_q, status_c;
	logic [cws_pkg::SEQ_W-1:0]     seq_q;
	logic [cws_pkg::COUNT_W-1:0]   count_q;
	logic [WW-1:0]                 cwin_out_q, thr_out_q;
	logic                          qe_q;

	logic                          advance;
	logic [CNT_W-1:0]              sw;
	logic [SEQ_BITS-1:0]           seq_c, ack_e, diff;
	logic [CNT_W-1:0]              grant_cnt, acked, queued_rel, sa_sub;
	logic signed [GW-1:0]          g_min, g_sw, g_adv, g_q1, g_q2;
	logic [1:0]                    dup_inc;
	logic                          dup;
	logic [WW:0]                   c_sum, s_sum;
	logic [WW-1:0]                 c_sat, t_half, sw16;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= cws_pkg::cmd_t'(s_tuser);
			ack_s1  <= s_tdata[cws_pkg::ACK_W-1:0];
			peer_s1 <= s_tdata[cws_pkg::ACK_W +: cws_pkg::PEER_W];
		end
	end

	always_comb begin
		if (slots_q == '0) begin
			sw = CNT_W'(1);
		end else if (32'(slots_q) > WINDOW_MAX) begin
			sw = CNT_W'(WINDOW_MAX);
		end else begin
			sw = CNT_W'(slots_q);
		end
	end

	// grant size: smallest of the window terms, floored at zero
	always_comb begin
		g_min = $signed(GW'(cwin_q)) - $signed(GW'(inf_q));
		g_sw  = $signed(GW'(sw));
		g_adv = $signed(GW'(adv_q)) - $signed(GW'(inf_q));
		g_q1  = $signed(GW'(queued_q)) - $signed(GW'(inf_q));
		g_q2  = $signed(GW'(queued_q)) - $signed(GW'(sa_q));
		if (g_sw < g_min)  g_min = g_sw;
		if (g_adv < g_min) g_min = g_adv;
		if (g_q1 < g_min)  g_min = g_q1;
		if (g_q2 < g_min)  g_min = g_q2;
		grant_cnt = (g_min < 0) ? '0 : CNT_W'(g_min);
	end

	assign ack_e   = SEQ_BITS'(ack_s1);
	assign diff    = ack_e - base_q;
	assign acked   = (diff > SEQ_BITS'(queued_q)) ? queued_q : CNT_W'(diff);
	assign dup     = (ack_e == last_q);
	assign dup_inc = dup_q + 2'd1;
	assign c_sum   = (WW+1)'(credit_q) + (WW+1)'(acked);
	assign c_sat   = c_sum[WW] ? cws_pkg::WIN_SAT : c_sum[WW-1:0];
	assign s_sum   = (WW+1)'(cwin_q) + (WW+1)'(acked);
	assign queued_rel = queued_q - acked;
	assign sa_sub  = (sa_q > acked) ? sa_q - acked : '0;
	assign t_half  = cwin_q >> 1;
	assign sw16    = WW'(sw);

	always_comb begin
		cwin_n   = cwin_q;
		ssth_n   = ssth_q;
		credit_n = credit_q;
		adv_n    = adv_q;
		inf_n    = inf_q;
		queued_n = queued_q;
		sa_n     = sa_q;
		base_n   = base_q;
		next_n   = next_q;
		last_n   = last_q;
		dup_n    = dup_q;
		status_c = cws_pkg::ST_ENQUEUED;
		seq_c    = '0;
		case (cmd_s1)
			cws_pkg::CMD_ENQUEUE: begin
				seq_c = next_q;
				if (queued_q >= sw) begin
					status_c = cws_pkg::ST_FULL;
				end else begin
					next_n   = next_q + SEQ_BITS'(1);
					queued_n = queued_q + CNT_W'(1);
				end
			end
			cws_pkg::CMD_GRANT: begin
				status_c = cws_pkg::ST_GRANT;
				seq_c    = base_q + SEQ_BITS'(sa_q);
				sa_n     = sa_q + grant_cnt;
				inf_n    = inf_q + grant_cnt;
			end
			cws_pkg::CMD_ACK: begin
				seq_c = ack_e;
				if (diff[SEQ_BITS-1]) begin
					status_c = cws_pkg::ST_OLD_ACK;
				end else if (dup && dup_inc == 2'd3) begin
					if (cwin_q > ssth_q) begin
						cwin_n = (ssth_q == '0) ? WW'(1) : ssth_q;
					end
					dup_n    = 2'd0;
					seq_c    = base_q;
					status_c = cws_pkg::ST_FAST_RETX;
				end else begin
					if (dup) begin
						dup_n    = dup_inc;
						status_c = cws_pkg::ST_DUP_ACK;
					end else begin
						inf_n    = (diff >= SEQ_BITS'(inf_q)) ? '0 : inf_q - CNT_W'(diff);
						last_n   = ack_e;
						dup_n    = 2'd0;
						status_c = cws_pkg::ST_ACK_DONE;
					end
					if (cwin_q >= ssth_q) begin
						if (c_sat >= cwin_q) begin
							credit_n = c_sat - cwin_q;
							if (cwin_q != cws_pkg::WIN_SAT) cwin_n = cwin_q + WW'(1);
						end else begin
							credit_n = c_sat;
						end
					end else begin
						cwin_n   = (s_sum > (WW+1)'(ssth_q)) ? ssth_q : s_sum[WW-1:0];
						credit_n = '0;
					end
					adv_n    = peer_s1;
					queued_n = queued_rel;
					base_n   = base_q + SEQ_BITS'(acked);
					sa_n     = (sa_sub > queued_rel) ? queued_rel : sa_sub;
				end
			end
			cws_pkg::CMD_TIMEOUT: begin
				sa_n     = '0;
				inf_n    = '0;
				seq_c    = base_q;
				status_c = cws_pkg::ST_TIMEOUT;
				if (adv_q == '0) begin
					adv_n = WW'(1);
				end else begin
					ssth_n = (t_half > sw16) ? sw16 : t_half;
					if (ssth_n < cws_pkg::MIN_THRESHOLD) ssth_n = cws_pkg::MIN_THRESHOLD;
					cwin_n   = WW'(1);
					credit_n = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= cws_pkg::RESET_SLOTS;
			cwin_q   <= WW'(1);
			ssth_q   <= cws_pkg::RESET_ADV;
			credit_q <= '0;
			adv_q    <= cws_pkg::RESET_ADV;
			inf_q    <= '0;
			queued_q <= '0;
			sa_q     <= '0;
			base_q   <= '0;
			next_q   <= '0;
			last_q   <= '0;
			dup_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == cws_pkg::REG_SLOTS) begin
				slots_q <= cfg_data[cws_pkg::SLOTS_W-1:0];
			end else begin
				ssth_q <= cfg_data[WW-1:0];
				adv_q  <= cfg_data[WW-1:0];
			end
		end else if (advance) begin
			cwin_q   <= cwin_n;
			ssth_q   <= ssth_n;
			credit_q <= credit_n;
			adv_q    <= adv_n;
			inf_q    <= inf_n;
			queued_q <= queued_n;
			sa_q     <= sa_n;
			base_q   <= base_n;
			next_q   <= next_n;
			last_q   <= last_n;
			dup_q    <= dup_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q   <= status_c;
			seq_q      <= cws_pkg::SEQ_W'(seq_c);
			count_q    <= (cmd_s1 == cws_pkg::CMD_GRANT) ?
				cws_pkg::COUNT_W'(grant_cnt) : '0;
			cwin_out_q <= cwin_n;
			thr_out_q  <= ssth_n;
			qe_q       <= (queued_n == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {6'd0, qe_q, thr_out_q, cwin_out_q, count_q, seq_q};

endmodule

/* hdl/cws_checker.sv */
module cws_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cws_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic [cws_pkg::M_TUSER_W-1:0]  m_tuser
);

	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without an accepted item");

	a_count_only_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != cws_pkg::ST_GRANT) |-> (m_tdata[40:32] == '0))
		else $error("nonzero count on a result other than a grant");

	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[56:41] != '0))
		else $error("congestion window reported as zero");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind congestion_window_sender cws_checker u_cws_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* test/tb_congestion_window_sender.sv */
module tb_congestion_window_sender;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 145;

	typedef struct {
		cws_pkg::status_t                status;
		logic [cws_pkg::SEQ_W-1:0]       seq;
		logic [cws_pkg::COUNT_W-1:0]     count;
		logic [cws_pkg::WIN_W-1:0]       cwin;
		logic [cws_pkg::WIN_W-1:0]       threshold;
		logic                            empty;
	} window_report_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [cws_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [cws_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	// ack_seq[31:0], peer_window[47:32]
	logic [cws_pkg::S_TDATA_W-1:0]      s_tdata = '0;
	// command[1:0]
	logic [cws_pkg::S_TUSER_W-1:0]      s_tuser = '0;
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	// seq[31:0], count[40:32], cwin_now[56:41], threshold_now[72:57], queue_empty[73]
	logic [cws_pkg::M_TDATA_W-1:0]      m_tdata;
	// status[2:0]
	logic [cws_pkg::M_TUSER_W-1:0]      m_tuser;

	window_report_t reports_due[$];
	int error_count = 0;
	int quiet_cycles = 0;
	int stall_phase = 0;
	int burst_left = 0;

	// tracked window state
	logic [cws_pkg::SLOTS_W-1:0] slots_cfg_m;
	logic [cws_pkg::WIN_W-1:0]   cwin_m, ssthr_m, credit_m, adv_m;
	logic [cws_pkg::SLOTS_W-1:0] flight_m, queued_m, ahead_m;
	logic [cws_pkg::SEQ_W-1:0]   base_m, next_m, lastack_m;
	logic [1:0]                  dupcnt_m;

	congestion_window_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned usable_slots();
		if (slots_cfg_m == 0) return 1;
		if (slots_cfg_m > cws_pkg::WINDOW_MAX_DEF) return cws_pkg::WINDOW_MAX_DEF;
		return slots_cfg_m;
	endfunction

	function automatic void grow_cwin(int unsigned acked);
		int unsigned credit;
		if (cwin_m >= ssthr_m) begin
			credit = credit_m + acked;
			if (credit > 65535) credit = 65535;
			if (credit >= cwin_m) begin
				credit = credit - cwin_m;
				if (cwin_m != cws_pkg::WIN_SAT) cwin_m = cwin_m + 1'b1;
			end
			credit_m = credit[cws_pkg::WIN_W-1:0];
		end else begin
			if (cwin_m + acked > ssthr_m) cwin_m = ssthr_m;
			else cwin_m = cwin_m + acked[cws_pkg::WIN_W-1:0];
			credit_m = '0;
		end
	endfunction

	function automatic window_report_t track_event(cws_pkg::cmd_t cmd,
			logic [cws_pkg::SEQ_W-1:0] ack, logic [cws_pkg::WIN_W-1:0] peer);
		window_report_t r;
		int sw, room, cw, fl, q, sa, av;
		logic [cws_pkg::SEQ_W-1:0] diff;
		int unsigned acked, half;
		bit dup;
		sw = usable_slots();
		r.count = '0;
		r.seq = '0;
		r.status = cws_pkg::ST_ENQUEUED;
		case (cmd)
			cws_pkg::CMD_ENQUEUE: begin
				r.seq = next_m;
				if (queued_m >= sw) begin
					r.status = cws_pkg::ST_FULL;
				end else begin
					r.status = cws_pkg::ST_ENQUEUED;
					next_m = next_m + 1'b1;
					queued_m = queued_m + 1'b1;
				end
			end
			cws_pkg::CMD_GRANT: begin
				cw = cwin_m;
				fl = flight_m;
				q = queued_m;
				sa = ahead_m;
				av = adv_m;
				room = cw - fl;
				if (sw < room) room = sw;
				if (av - fl < room) room = av - fl;
				if (q - fl < room) room = q - fl;
				if (q - sa < room) room = q - sa;
				if (room < 0) room = 0;
				r.count = cws_pkg::COUNT_W'(room);
				r.seq = base_m + ahead_m;
				ahead_m = ahead_m + cws_pkg::SLOTS_W'(room);
				flight_m = flight_m + cws_pkg::SLOTS_W'(room);
				r.status = cws_pkg::ST_GRANT;
			end
			cws_pkg::CMD_ACK: begin
				diff = ack - base_m;
				r.seq = ack;
				if (diff[cws_pkg::SEQ_W-1]) begin
					r.status = cws_pkg::ST_OLD_ACK;
				end else begin
					acked = (diff > queued_m) ? queued_m : diff;
					dup = (ack == lastack_m);
					if (dup) begin
						dupcnt_m = dupcnt_m + 1'b1;
					end else begin
						flight_m = (diff >= flight_m) ? '0
							: flight_m - diff[cws_pkg::SLOTS_W-1:0];
						lastack_m = ack;
						dupcnt_m = '0;
					end
					if (dup && dupcnt_m == 2'd3) begin
						if (cwin_m > ssthr_m) cwin_m = (ssthr_m == 0) ? 16'd1 : ssthr_m;
						dupcnt_m = '0;
						r.seq = base_m;
						r.status = cws_pkg::ST_FAST_RETX;
					end else begin
						grow_cwin(acked);
						adv_m = peer;
						queued_m = queued_m - cws_pkg::SLOTS_W'(acked);
						base_m = base_m + acked;
						ahead_m = (ahead_m > acked) ? ahead_m - cws_pkg::SLOTS_W'(acked) : '0;
						if (ahead_m > queued_m) ahead_m = queued_m;
						r.status = dup ? cws_pkg::ST_DUP_ACK : cws_pkg::ST_ACK_DONE;
					end
				end
			end
			cws_pkg::CMD_TIMEOUT: begin
				ahead_m = '0;
				flight_m = '0;
				if (adv_m == 0) begin
					adv_m = 16'd1;
				end else begin
					half = cwin_m / 2;
					if (half > sw) half = sw;
					if (half < cws_pkg::MIN_THRESHOLD) half = cws_pkg::MIN_THRESHOLD;
					ssthr_m = cws_pkg::WIN_W'(half);
					cwin_m = 16'd1;
					credit_m = '0;
				end
				r.seq = base_m;
				r.status = cws_pkg::ST_TIMEOUT;
			end
			default: begin
			end
		endcase
		r.cwin = cwin_m;
		r.threshold = ssthr_m;
		r.empty = (queued_m == 0);
		return r;
	endfunction

	task automatic push_event(cws_pkg::cmd_t cmd, logic [cws_pkg::SEQ_W-1:0] ack,
			logic [cws_pkg::WIN_W-1:0] peer);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {peer, ack};
		do @(posedge clk); while (!s_tready);
		reports_due.push_back(track_event(cmd, ack, peer));
		@(negedge clk);
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (reports_due.size() != 0);
	endtask

	task automatic write_reg(cws_pkg::reg_idx_t idx, logic [cws_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cws_pkg::REG_SLOTS: slots_cfg_m = value[cws_pkg::SLOTS_W-1:0];
			cws_pkg::REG_INIT_ADV: begin
				ssthr_m = value;
				adv_m = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic test_enqueue_limits();
		write_reg(cws_pkg::REG_SLOTS, 16'd1);
		push_event(cws_pkg::CMD_ENQUEUE, '0, '0);
		push_event(cws_pkg::CMD_ENQUEUE, '1, '1);
		settle();
		write_reg(cws_pkg::REG_SLOTS, 16'd0);
		push_event(cws_pkg::CMD_ENQUEUE, '0, '0);
		settle();
		write_reg(cws_pkg::REG_SLOTS, 16'd511);
		push_event(cws_pkg::CMD_ENQUEUE, '0, '0);
	endtask

	task automatic test_grant_limits();
		push_event(cws_pkg::CMD_GRANT, '0, '0);
		push_event(cws_pkg::CMD_GRANT, '0, '0);
	endtask

	task automatic test_ack_handling();
		push_event(cws_pkg::CMD_ACK, 32'h8000_0000, 16'd5);
		push_event(cws_pkg::CMD_ACK, 32'hFFFF_FFFF, 16'd5);
		push_event(cws_pkg::CMD_ACK, 32'h7FFF_FFFF, 16'd0);
		repeat (3) push_event(cws_pkg::CMD_ACK, 32'h7FFF_FFFF, 16'd0);
	endtask

	task automatic test_timeout_paths();
		push_event(cws_pkg::CMD_TIMEOUT, '0, '0);
		push_event(cws_pkg::CMD_TIMEOUT, '0, '0);
	endtask

	task automatic test_window_floor();
		logic [cws_pkg::SEQ_W-1:0] ack;
		settle();
		write_reg(cws_pkg::REG_INIT_ADV, 16'd0);
		push_event(cws_pkg::CMD_ENQUEUE, '0, '0);
		push_event(cws_pkg::CMD_ENQUEUE, '0, '0);
		ack = base_m + 1'b1;
		push_event(cws_pkg::CMD_ACK, ack, 16'hFFFF);
		push_event(cws_pkg::CMD_GRANT, '0, '0);
		push_event(cws_pkg::CMD_ACK, ack, 16'd0);
		push_event(cws_pkg::CMD_GRANT, '0, '0);
		push_event(cws_pkg::CMD_ACK, ack, 16'd0);
		push_event(cws_pkg::CMD_ACK, ack, 16'd0);
		push_event(cws_pkg::CMD_TIMEOUT, '0, '0);
	endtask

	task automatic random_event();
		int pick;
		logic [cws_pkg::WIN_W-1:0] peer;
		logic [cws_pkg::SEQ_W-1:0] ack;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: peer = '0;
			1: peer = '1;
			2, 3: peer = cws_pkg::WIN_W'($urandom_range(0, 65535));
			default: peer = cws_pkg::WIN_W'($urandom_range(1, 48));
		endcase
		if (pick < 35) begin
			push_event(cws_pkg::CMD_ENQUEUE, $urandom(), cws_pkg::WIN_W'($urandom()));
		end else if (pick < 60) begin
			push_event(cws_pkg::CMD_GRANT, $urandom(), cws_pkg::WIN_W'($urandom()));
		end else if (pick < 80) begin
			ack = base_m + $urandom_range(0, queued_m + 2);
			push_event(cws_pkg::CMD_ACK, ack, peer);
		end else if (pick < 88) begin
			ack = lastack_m;
			repeat (3) push_event(cws_pkg::CMD_ACK, ack, peer);
		end else if (pick < 94) begin
			push_event(cws_pkg::CMD_ACK, $urandom(), peer);
		end else begin
			push_event(cws_pkg::CMD_TIMEOUT, $urandom(), cws_pkg::WIN_W'($urandom()));
		end
	endtask

	task automatic test_random_traffic();
		int slots_set[7];
		int adv_set[7];
		slots_set = '{16, 1, 256, 0, 511, 37, 0};
		adv_set = '{16, 3, 65535, 0, 100, 40, 0};
		slots_set[6] = $urandom_range(1, 256);
		adv_set[6] = $urandom_range(0, 65535);
		for (int p = 0; p < 7; p++) begin
			settle();
			write_reg(cws_pkg::REG_SLOTS, cws_pkg::CFG_DATA_W'(slots_set[p]));
			write_reg(cws_pkg::REG_INIT_ADV, cws_pkg::CFG_DATA_W'(adv_set[p]));
			repeat (PHASE_ITEMS) random_event();
		end
	endtask

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		window_report_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (reports_due.size() == 0) begin
				$error("unexpected item: status %0d seq %0h", m_tuser, m_tdata[31:0]);
				error_count++;
			end else begin
				due = reports_due.pop_front();
				compare_field("status", due.status, m_tuser);
				compare_field("seq", due.seq, m_tdata[31:0]);
				compare_field("count", due.count, m_tdata[40:32]);
				compare_field("cwin_now", due.cwin, m_tdata[56:41]);
				compare_field("threshold_now", due.threshold, m_tdata[72:57]);
				compare_field("queue_empty", due.empty, m_tdata[73]);
			end
		end
	end

	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase / 256) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 1);
			2: m_tready <= (stall_phase % 4 != 0);
			default: m_tready <= (stall_phase % 37 >= 10);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb_congestion_window_sender: done, errors");
			$finish;
		end
	end

	initial begin
		slots_cfg_m = cws_pkg::RESET_SLOTS;
		cwin_m = 16'd1;
		ssthr_m = cws_pkg::RESET_ADV;
		adv_m = cws_pkg::RESET_ADV;
		credit_m = '0;
		flight_m = '0;
		queued_m = '0;
		ahead_m = '0;
		base_m = '0;
		next_m = '0;
		lastack_m = '0;
		dupcnt_m = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_enqueue_limits();
		test_grant_limits();
		test_ack_handling();
		test_timeout_paths();
		test_window_floor();
		test_random_traffic();
		settle();
		repeat (4) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_congestion_window_sender: done, clean");
		end else begin
			$display("tb_congestion_window_sender: done, errors");
		end
		$finish;
	end

endmodule
